/* hw/rtl/swrl_pkg.sv */
package swrl_pkg;

  localparam int unsigned WindowDef = 10;
  localparam int unsigned RateW     = 24;
  localparam int unsigned BytesW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TotalW    = 20;
  localparam int unsigned DelayW    = 26;
  localparam int unsigned CountW    = 32;
  localparam int unsigned AluW      = 32;
  localparam int unsigned DivSteps  = DelayW;

  // 1000 = 1024 - 16 - 8
  localparam int unsigned MulShA = 10;
  localparam int unsigned MulShB = 4;
  localparam int unsigned MulShC = 3;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_SEND    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CMP,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_ELAPSED,
    ST_READY
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic              advance;
    logic [BytesW-1:0] wr_data;
  } ring_ctrl_t;

endpackage

/* hw/rtl/swrl_if.sv */
interface swrl_in_if import swrl_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               operation;
  logic [BytesW-1:0] packet_bytes;
  logic              is_spawned;
  logic [TimeW-1:0]  now_ms;

  modport source (output valid, operation, packet_bytes, is_spawned, now_ms, input ready);
  modport sink (input valid, operation, packet_bytes, is_spawned, now_ms, output ready);
endinterface

interface swrl_out_if import swrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_dropped;
  logic [TotalW-1:0] window_total;
  logic              send_ready;
  logic [DelayW-1:0] send_delay_ms;
  logic [CountW-1:0] suppressed_count;

  modport source (output valid, frame_dropped, window_total, send_ready, send_delay_ms,
                  suppressed_count, input ready);
  modport sink (input valid, frame_dropped, window_total, send_ready, send_delay_ms,
                suppressed_count, output ready);
endinterface

interface swrl_cfg_if import swrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RateW-1:0] rate_bytes_per_sec;

  modport source (output valid, rate_bytes_per_sec, input ready);
  modport sink (input valid, rate_bytes_per_sec, output ready);
endinterface

/* hw/rtl/swrl_alu.sv */
module swrl_alu import swrl_pkg::*; (
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  input  logic            sub_i,
  output logic [AluW:0]   res_o
);

  always_comb begin
    if (sub_i) begin
      res_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      res_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

endmodule

/* hw/rtl/swrl_ring.sv */
module swrl_ring import swrl_pkg::*; #(
  parameter int unsigned Window = WindowDef,
  parameter int unsigned IdxW   = (Window > 1) ? $clog2(Window) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctrl_t        ctrl_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output logic [BytesW-1:0] rd_data_o
);

  logic [BytesW-1:0] size_q [Window];
  logic [IdxW-1:0]   slot_q;
  logic [IdxW-1:0]   slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.advance) begin
      if (slot_q == IdxW'(Window - 1)) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int i = 0; i < Window; i++) begin
        size_q[i] <= '0;
      end
    end else begin
      slot_q <= slot_d;
      if (ctrl_i.wr_en) begin
        size_q[slot_q] <= ctrl_i.wr_data;
      end
    end
  end

  assign rd_data_o = size_q[rd_idx_i];

endmodule

/* hw/rtl/sliding_window_rate_limiter.sv */
// A frame check sums the ring and compares; a record send at nonzero rate
// multiplies and divides; every item then takes the elapsed-time step.
// Throughput: one item at a time; the next item is accepted the cycle after
// the result is registered. The ring sum and the 26-step restoring divide
// both run on one shared 32-bit adder/subtractor.
// Reset (rst_ni, async, active low) clears the ring, pointers, tally and rate.
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int unsigned Window = WindowDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swrl_cfg_if.sink     cfg_i,
  swrl_in_if.sink      in_i,
  swrl_out_if.source   out_o
);

  localparam int unsigned IdxW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned DivW = $clog2(DivSteps);
  localparam int unsigned CntW = (IdxW > DivW) ? IdxW : DivW;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RateW-1:0]  rate_q;
  logic [CountW-1:0] drop_q, drop_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic              out_valid_q, out_valid_d;

  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [AluW-1:0]   acc_q, acc_d;
  logic [RateW-1:0]  rem_q, rem_d;
  logic [DelayW-1:0] quo_q, quo_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              dropped_q, dropped_d;
  logic              out_dropped_q, out_dropped_d;
  logic [TotalW-1:0] out_total_q, out_total_d;
  logic              out_sready_q, out_sready_d;
  logic [DelayW-1:0] out_delay_q, out_delay_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  logic              in_xfer;
  logic              out_free;
  logic              last_sum;
  logic              last_div;
  logic              cmp_drop;
  logic [RateW:0]    rem_sh;
  logic [AluW-1:0]   alu_a, alu_b;
  logic              alu_sub;
  logic [AluW:0]     alu_res;
  ring_ctrl_t        ring_ctrl;
  logic [BytesW-1:0] ring_rd;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last_sum = (cnt_q == CntW'(Window - 1));
  assign last_div = (cnt_q == CntW'(DivSteps - 1));
  assign rem_sh   = {rem_q, quo_q[DelayW-1]};
  assign cmp_drop = (rate_q != '0) && alu_res[AluW];

  swrl_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  swrl_ring #(
    .Window (Window),
    .IdxW   (IdxW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ring_ctrl),
    .rd_idx_i  (cnt_q[IdxW-1:0]),
    .rd_data_o (ring_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_i.operation)
            OP_CHECK: state_d = ST_SUM;
            OP_SEND:  state_d = (rate_q != '0) ? ST_MUL_A : ST_ELAPSED;
            default:  state_d = ST_ELAPSED;
          endcase
        end
      end
      ST_SUM:     if (last_sum) state_d = ST_CMP;
      ST_CMP:     state_d = ST_ELAPSED;
      ST_MUL_A:   state_d = ST_MUL_B;
      ST_MUL_B:   state_d = ST_DIV;
      ST_DIV:     if (last_div) state_d = ST_ELAPSED;
      ST_ELAPSED: state_d = ST_READY;
      ST_READY:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    ring_ctrl  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_i.operation == OP_SEND && rate_q != '0 && in_i.is_spawned) begin
          ring_ctrl.wr_en   = 1'b1;
          ring_ctrl.wr_data = in_i.packet_bytes;
        end
        ring_ctrl.advance = in_xfer && (in_i.operation == OP_ADVANCE);
      end
      ST_SUM: begin
        alu_a = acc_q;
        alu_b = AluW'(ring_rd);
      end
      ST_CMP: begin
        alu_a   = AluW'(rate_q);
        alu_b   = acc_q;
        alu_sub = 1'b1;
        ring_ctrl.wr_en = cmp_drop;
      end
      ST_MUL_A: begin
        alu_a   = AluW'(bytes_q) << MulShA;
        alu_b   = AluW'(bytes_q) << MulShB;
        alu_sub = 1'b1;
      end
      ST_MUL_B: begin
        alu_a   = acc_q;
        alu_b   = AluW'(bytes_q) << MulShC;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = AluW'(rem_sh);
        alu_b   = AluW'(rate_q);
        alu_sub = 1'b1;
      end
      ST_ELAPSED: begin
        alu_a   = now_q;
        alu_b   = last_q;
        alu_sub = 1'b1;
      end
      ST_READY: begin
        alu_a   = acc_q;
        alu_b   = AluW'(delay_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    cnt_d         = cnt_q;
    drop_d        = drop_q;
    last_d        = last_q;
    delay_d       = delay_q;
    out_valid_d   = out_valid_q;
    bytes_d       = bytes_q;
    now_d         = now_q;
    acc_d         = acc_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    total_d       = total_q;
    dropped_d     = dropped_q;
    out_dropped_d = out_dropped_q;
    out_total_d   = out_total_q;
    out_sready_d  = out_sready_q;
    out_delay_d   = out_delay_q;
    out_count_d   = out_count_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          bytes_d   = in_i.packet_bytes;
          now_d     = in_i.now_ms;
          acc_d     = '0;
          cnt_d     = '0;
          total_d   = '0;
          dropped_d = 1'b0;
          if (in_i.operation == OP_SEND) begin
            last_d = in_i.now_ms;
            if (rate_q == '0) begin
              delay_d = '0;
            end
          end
        end
      end
      ST_SUM: begin
        acc_d = alu_res[AluW-1:0];
        cnt_d = cnt_q + CntW'(1);
      end
      ST_CMP: begin
        total_d = acc_q[TotalW-1:0];
        if (cmp_drop) begin
          dropped_d = 1'b1;
          drop_d    = drop_q + CountW'(1);
        end
      end
      ST_MUL_A: begin
        acc_d = alu_res[AluW-1:0];
      end
      ST_MUL_B: begin
        quo_d = alu_res[DelayW-1:0];
        rem_d = '0;
        cnt_d = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (!alu_res[AluW]) begin
          rem_d = alu_res[RateW-1:0];
          quo_d = {quo_q[DelayW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[RateW-1:0];
          quo_d = {quo_q[DelayW-2:0], 1'b0};
        end
        if (last_div) begin
          delay_d = quo_d;
        end
      end
      ST_ELAPSED: begin
        acc_d = alu_res[AluW-1:0];
      end
      ST_READY: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_dropped_d = dropped_q;
          out_total_d   = total_q;
          out_sready_d  = !alu_res[AluW];
          out_delay_d   = delay_q;
          out_count_d   = drop_q;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rate_q      <= '0;
      drop_q      <= '0;
      last_q      <= '0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      last_q      <= last_d;
      delay_q     <= delay_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        rate_q <= cfg_i.rate_bytes_per_sec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q       <= bytes_d;
    now_q         <= now_d;
    acc_q         <= acc_d;
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    total_q       <= total_d;
    dropped_q     <= dropped_d;
    out_dropped_q <= out_dropped_d;
    out_total_q   <= out_total_d;
    out_sready_q  <= out_sready_d;
    out_delay_q   <= out_delay_d;
    out_count_q   <= out_count_d;
  end

  assign cfg_i.ready            = 1'b1;
  assign out_o.valid            = out_valid_q;
  assign out_o.frame_dropped    = out_dropped_q;
  assign out_o.window_total     = out_total_q;
  assign out_o.send_ready       = out_sready_q;
  assign out_o.send_delay_ms    = out_delay_q;
  assign out_o.suppressed_count = out_count_q;

endmodule

/* hw/rtl/swrl_checker.sv */
module swrl_checker import swrl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              frame_dropped_i,
  input logic [TotalW-1:0] window_total_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after transfer");

  a_drop_needs_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && frame_dropped_i) |-> (window_total_i != '0))
    else $error("frame dropped with empty window");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(frame_dropped_i)
                                       && $stable(window_total_i)))
    else $error("stalled result changed");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .frame_dropped_i (out_o.frame_dropped),
  .window_total_i  (out_o.window_total)
);
